### hw/rtl/icalc_pkg.sv
// Shared types and constants for the integer calculator ALU.
// Holds operation codes, status codes and the multiplier digit width.
// No dependencies.
package icalc_pkg;

    typedef logic [2:0] op_t;
    typedef logic [1:0] status_t;

    localparam op_t OP_ADD     = 3'd0;
    localparam op_t OP_SUB     = 3'd1;
    localparam op_t OP_MUL     = 3'd2;
    localparam op_t OP_DIV     = 3'd3;
    localparam op_t OP_REM     = 3'd4;
    localparam op_t OP_FACT    = 3'd5;
    localparam op_t OP_POW     = 3'd6;
    localparam op_t OP_INVALID = 3'd7;

    localparam status_t ST_OK       = 2'd0;
    localparam status_t ST_DIV_ZERO = 2'd1;
    localparam status_t ST_INVALID  = 2'd2;

    localparam int DIGIT_W = 8;

endpackage

### hw/rtl/icalc_mul.sv
// Iterative multiplier returning the low DATA_WIDTH bits of a product.
// Consumes one multiplier digit of icalc_pkg::DIGIT_W bits per cycle.
// Depends on icalc_pkg.
module icalc_mul #(
    parameter int DATA_WIDTH = 32
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [DATA_WIDTH-1:0] mcand,
    input  logic [DATA_WIDTH-1:0] mplier,
    output logic                  done,
    output logic [DATA_WIDTH-1:0] product
);

    localparam int DIGW   = icalc_pkg::DIGIT_W;
    localparam int DIGITS = (DATA_WIDTH + DIGW - 1) / DIGW;
    localparam int CNT_W  = $clog2(DIGITS + 1);

    logic                       busy_reg;
    logic                       done_reg;
    logic [CNT_W-1:0]           cnt_reg;
    logic [DATA_WIDTH-1:0]      mcand_reg;
    logic [DATA_WIDTH-1:0]      mplier_reg;
    logic [DATA_WIDTH-1:0]      acc_reg;
    logic [DATA_WIDTH+DIGW-1:0] partial;

    assign partial = mcand_reg * mplier_reg[DIGW-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(DIGITS);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            mcand_reg  <= mcand;
            mplier_reg <= mplier;
            acc_reg    <= '0;
        end
        else if (busy_reg)
        begin
            acc_reg    <= acc_reg + partial[DATA_WIDTH-1:0];
            mcand_reg  <= mcand_reg << DIGW;
            mplier_reg <= mplier_reg >> DIGW;
        end
    end

    assign done    = done_reg;
    assign product = acc_reg;

endmodule

### hw/rtl/icalc_div.sv
// Restoring unsigned divider producing quotient and remainder.
// Resolves one quotient bit per cycle; no package dependencies.
module icalc_div #(
    parameter int DATA_WIDTH = 32
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [DATA_WIDTH-1:0] dividend,
    input  logic [DATA_WIDTH-1:0] divisor,
    output logic                  done,
    output logic [DATA_WIDTH-1:0] quotient,
    output logic [DATA_WIDTH-1:0] remainder
);

    localparam int CNT_W = $clog2(DATA_WIDTH + 1);

    logic                  busy_reg;
    logic                  done_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic [DATA_WIDTH-1:0] quo_reg;
    logic [DATA_WIDTH-1:0] rem_reg;
    logic [DATA_WIDTH-1:0] den_reg;
    logic [DATA_WIDTH:0]   shifted;
    logic [DATA_WIDTH+1:0] diff;
    logic                  borrow;

    assign shifted = {rem_reg, quo_reg[DATA_WIDTH-1]};
    assign diff    = {1'b0, shifted} - {2'b00, den_reg};
    assign borrow  = diff[DATA_WIDTH+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(DATA_WIDTH);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            den_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[DATA_WIDTH-2:0], ~borrow};
            rem_reg <= borrow ? shifted[DATA_WIDTH-1:0] : diff[DATA_WIDTH-1:0];
        end
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

### hw/rtl/integer_calc_alu_top.sv
// Top level of the integer calculator ALU: stream ports and the sequencer.
// Depends on icalc_pkg, icalc_mul and icalc_div.
//
//  Channel  Direction  Signals               Contents
//  s_axis   in         tvalid/tready/tdata   tdata: operand_a, operand_b
//                      tuser                 tuser: req_type
//  m_axis   out        tvalid/tready/tdata   tdata: value_first, value_second
//                      tuser                 tuser: status
//
// Add, subtract, invalid codes and zero divisors are resolved on acceptance and go
// straight to S_DONE; multiply uses the shared multiplier over DATA_WIDTH / 8
// digits rounded up, divide and remainder the divider. Power squares the base for
// each exponent bit and multiplies it into the result for each set bit; factorial
// does at most one multiply per factor for each operand, both on the shared
// multiplier that retires 8 bits per cycle. Reset is asynchronous and clears the
// sequencer and the output valid. The next beat is accepted while a result waits in
// the output register; a finished result waits for it to free.
module integer_calc_alu_top #(
    parameter int DATA_WIDTH = 32
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   s_axis_tvalid,
    output logic                                   s_axis_tready,
    // operand_a, operand_b, zero fill
    input  logic [((2*DATA_WIDTH+7)/8)*8-1:0]      s_axis_tdata,
    // req_type
    input  logic [2:0]                             s_axis_tuser,
    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    // value_first, value_second, zero fill
    output logic [((2*DATA_WIDTH+7)/8)*8-1:0]      m_axis_tdata,
    // status
    output logic [1:0]                             m_axis_tuser
);

    localparam int DW = DATA_WIDTH;

    localparam logic [3:0] S_IDLE      = 4'd0;
    localparam logic [3:0] S_MUL_GO    = 4'd1;
    localparam logic [3:0] S_MUL_WAIT  = 4'd2;
    localparam logic [3:0] S_DIV_GO    = 4'd3;
    localparam logic [3:0] S_DIV_WAIT  = 4'd4;
    localparam logic [3:0] S_FACT_INIT = 4'd5;
    localparam logic [3:0] S_FACT_GO   = 4'd6;
    localparam logic [3:0] S_FACT_WAIT = 4'd7;
    localparam logic [3:0] S_POW_CHK   = 4'd8;
    localparam logic [3:0] S_POW_AGO   = 4'd9;
    localparam logic [3:0] S_POW_AWAIT = 4'd10;
    localparam logic [3:0] S_POW_SGO   = 4'd11;
    localparam logic [3:0] S_POW_SWAIT = 4'd12;
    localparam logic [3:0] S_DONE      = 4'd13;

    logic [3:0]            state_reg, state_next;
    logic                  fsel_reg, fsel_next;
    logic                  out_valid_reg, out_valid_next;
    icalc_pkg::op_t        op_reg, op_next;
    logic [DW-1:0]         a_reg, a_next;
    logic [DW-1:0]         b_reg, b_next;
    icalc_pkg::status_t    st_reg, st_next;
    logic [DW-1:0]         v1_reg, v1_next;
    logic [DW-1:0]         v2_reg, v2_next;
    logic [DW-1:0]         acc_reg, acc_next;
    logic [DW-1:0]         sq_reg, sq_next;
    logic [DW-1:0]         e_reg, e_next;
    logic [DW-1:0]         i_reg, i_next;
    icalc_pkg::status_t    out_st_reg, out_st_next;
    logic [DW-1:0]         out_v1_reg, out_v1_next;
    logic [DW-1:0]         out_v2_reg, out_v2_next;

    logic [DW-1:0]         in_a;
    logic [DW-1:0]         in_b;
    logic [DW-1:0]         abs_a;
    logic [DW-1:0]         abs_b;
    logic [DW-1:0]         fact_n;
    logic                  mul_start;
    logic [DW-1:0]         mul_x;
    logic [DW-1:0]         mul_y;
    logic                  mul_done;
    logic [DW-1:0]         mul_prod;
    logic                  div_start;
    logic                  div_done;
    logic [DW-1:0]         div_q;
    logic [DW-1:0]         div_r;

    assign in_a   = s_axis_tdata[DW-1:0];
    assign in_b   = s_axis_tdata[2*DW-1:DW];
    assign abs_a  = a_reg[DW-1] ? (~a_reg + 1'b1) : a_reg;
    assign abs_b  = b_reg[DW-1] ? (~b_reg + 1'b1) : b_reg;
    assign fact_n = fsel_reg ? b_reg : a_reg;

    icalc_mul #(
        .DATA_WIDTH (DW)
    ) u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .mcand   (mul_x),
        .mplier  (mul_y),
        .done    (mul_done),
        .product (mul_prod)
    );

    icalc_div #(
        .DATA_WIDTH (DW)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (abs_a),
        .divisor   (abs_b),
        .done      (div_done),
        .quotient  (div_q),
        .remainder (div_r)
    );

    always_comb
    begin
        state_next     = state_reg;
        fsel_next      = fsel_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        op_next        = op_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        st_next        = st_reg;
        v1_next        = v1_reg;
        v2_next        = v2_reg;
        acc_next       = acc_reg;
        sq_next        = sq_reg;
        e_next         = e_reg;
        i_next         = i_reg;
        out_st_next    = out_st_reg;
        out_v1_next    = out_v1_reg;
        out_v2_next    = out_v2_reg;
        mul_start      = 1'b0;
        mul_x          = a_reg;
        mul_y          = b_reg;
        div_start      = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    op_next   = s_axis_tuser;
                    a_next    = in_a;
                    b_next    = in_b;
                    st_next   = icalc_pkg::ST_OK;
                    v1_next   = '0;
                    v2_next   = '0;
                    fsel_next = 1'b0;
                    acc_next  = DW'(1);
                    sq_next   = in_a;
                    e_next    = in_b;
                    unique case (s_axis_tuser) inside
                        icalc_pkg::OP_ADD:
                        begin
                            v1_next    = in_a + in_b;
                            state_next = S_DONE;
                        end
                        icalc_pkg::OP_SUB:
                        begin
                            v1_next    = in_a - in_b;
                            state_next = S_DONE;
                        end
                        icalc_pkg::OP_MUL:
                        begin
                            state_next = S_MUL_GO;
                        end
                        icalc_pkg::OP_DIV, icalc_pkg::OP_REM:
                        begin
                            if (in_b == '0)
                            begin
                                st_next    = icalc_pkg::ST_DIV_ZERO;
                                state_next = S_DONE;
                            end
                            else
                            begin
                                state_next = S_DIV_GO;
                            end
                        end
                        icalc_pkg::OP_FACT:
                        begin
                            state_next = S_FACT_INIT;
                        end
                        icalc_pkg::OP_POW:
                        begin
                            if (in_b[DW-1])
                            begin
                                v1_next    = DW'(1);
                                state_next = S_DONE;
                            end
                            else
                            begin
                                state_next = S_POW_CHK;
                            end
                        end
                        default:
                        begin
                            st_next    = icalc_pkg::ST_INVALID;
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_MUL_GO:
            begin
                mul_start  = 1'b1;
                state_next = S_MUL_WAIT;
            end
            S_MUL_WAIT:
            begin
                if (mul_done)
                begin
                    v1_next    = mul_prod;
                    state_next = S_DONE;
                end
            end
            S_DIV_GO:
            begin
                div_start  = 1'b1;
                state_next = S_DIV_WAIT;
            end
            S_DIV_WAIT:
            begin
                if (div_done)
                begin
                    if (op_reg == icalc_pkg::OP_DIV)
                    begin
                        v1_next = (a_reg[DW-1] ^ b_reg[DW-1]) ? (~div_q + 1'b1) : div_q;
                    end
                    else
                    begin
                        v1_next = a_reg[DW-1] ? (~div_r + 1'b1) : div_r;
                    end
                    state_next = S_DONE;
                end
            end
            S_FACT_INIT:
            begin
                if (fact_n[DW-1] || fact_n == '0)
                begin
                    if (!fsel_reg)
                    begin
                        v1_next    = DW'(1);
                        fsel_next  = 1'b1;
                        state_next = S_FACT_INIT;
                    end
                    else
                    begin
                        v2_next    = DW'(1);
                        state_next = S_DONE;
                    end
                end
                else
                begin
                    acc_next   = DW'(1);
                    i_next     = DW'(1);
                    state_next = S_FACT_GO;
                end
            end
            S_FACT_GO:
            begin
                mul_start  = 1'b1;
                mul_x      = acc_reg;
                mul_y      = i_reg;
                state_next = S_FACT_WAIT;
            end
            S_FACT_WAIT:
            begin
                if (mul_done)
                begin
                    acc_next = mul_prod;
                    if (mul_prod == '0 || i_reg == fact_n)
                    begin
                        if (!fsel_reg)
                        begin
                            v1_next    = mul_prod;
                            fsel_next  = 1'b1;
                            state_next = S_FACT_INIT;
                        end
                        else
                        begin
                            v2_next    = mul_prod;
                            state_next = S_DONE;
                        end
                    end
                    else
                    begin
                        i_next     = i_reg + 1'b1;
                        state_next = S_FACT_GO;
                    end
                end
            end
            S_POW_CHK:
            begin
                if (e_reg == '0)
                begin
                    v1_next    = acc_reg;
                    state_next = S_DONE;
                end
                else if (e_reg[0])
                begin
                    state_next = S_POW_AGO;
                end
                else
                begin
                    state_next = S_POW_SGO;
                end
            end
            S_POW_AGO:
            begin
                mul_start  = 1'b1;
                mul_x      = acc_reg;
                mul_y      = sq_reg;
                state_next = S_POW_AWAIT;
            end
            S_POW_AWAIT:
            begin
                if (mul_done)
                begin
                    acc_next   = mul_prod;
                    state_next = S_POW_SGO;
                end
            end
            S_POW_SGO:
            begin
                mul_start  = 1'b1;
                mul_x      = sq_reg;
                mul_y      = sq_reg;
                state_next = S_POW_SWAIT;
            end
            S_POW_SWAIT:
            begin
                if (mul_done)
                begin
                    sq_next    = mul_prod;
                    e_next     = e_reg >> 1;
                    state_next = S_POW_CHK;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_st_next    = st_reg;
                    out_v1_next    = v1_reg;
                    out_v2_next    = v2_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            fsel_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fsel_reg      <= fsel_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        a_reg      <= a_next;
        b_reg      <= b_next;
        st_reg     <= st_next;
        v1_reg     <= v1_next;
        v2_reg     <= v2_next;
        acc_reg    <= acc_next;
        sq_reg     <= sq_next;
        e_reg      <= e_next;
        i_reg      <= i_next;
        out_st_reg <= out_st_next;
        out_v1_reg <= out_v1_next;
        out_v2_reg <= out_v2_next;
    end

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_st_reg;

    always_comb
    begin
        m_axis_tdata = '0;
        m_axis_tdata[2*DW-1:0] = {out_v2_reg, out_v1_reg};
    end

endmodule
